### rtl/ghsp_pkg.sv
// Shared types and constants for the ghost / scanline pixel effect.
// No dependencies.
package ghsp_pkg;

    localparam int unsigned PIX_W   = 32;
    localparam int unsigned ADDR_W  = 6;
    localparam int unsigned DEPTH   = 1 << ADDR_W;
    localparam int unsigned COL_W   = 10;
    localparam int unsigned DIM_W   = 11;
    localparam int unsigned CFG_W   = 11;
    localparam int unsigned IDX_W   = 3;
    localparam int unsigned CNT_W   = 7;
    localparam int unsigned CH_W    = 8;
    localparam int unsigned RECIP_W = 17;
    localparam int unsigned DIV_N   = 16;

    localparam logic [DIM_W-1:0]   MAX_WIDTH   = 11'd1024;
    localparam logic [CH_W-1:0]    CH_MAX      = 8'd255;
    localparam logic [RECIP_W-1:0] RECIP_RESET = 17'd32768;

    typedef enum logic [IDX_W-1:0] {
        REG_MODE    = 3'd0,
        REG_WIDTH   = 3'd1,
        REG_HEIGHT  = 3'd2,
        REG_OFFSET  = 3'd3,
        REG_DIVISOR = 3'd4,
        REG_PERIOD  = 3'd5,
        REG_DARKEN  = 3'd6
    } cfg_reg_t;

    typedef enum logic [1:0] {
        MODE_PASS  = 2'd0,
        MODE_GHOST = 2'd1,
        MODE_SCAN  = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RECIP_WAIT,
        ST_PHASE_WAIT,
        ST_READ,
        ST_LOAD,
        ST_HOLD
    } state_t;

    typedef struct packed {
        logic item_take;
        logic div_start;
        logic div_sel_phase;
        logic store_recip;
        logic store_phase;
        logic mem_rd;
        logic out_load;
        logic advance;
    } cmd_t;

    typedef struct packed {
        logic wr_divisor;
        logic wr_period;
        logic div_done;
        logic has_results;
        logic more;
    } status_t;

endpackage

### rtl/ghsp_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on ghsp_pkg.
module ghsp_div import ghsp_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [DIV_N-1:0]    dividend,
    input  logic [CH_W-1:0]     divisor,
    output logic                done,
    output logic [DIV_N-1:0]    quotient,
    output logic [CH_W-1:0]     remainder
);

    logic [DIV_N-1:0] quo_reg, quo_next;
    logic [CH_W-1:0]  rem_reg, rem_next;
    logic [CH_W-1:0]  dvs_reg;
    logic [4:0]       cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CH_W:0]    trial;
    logic [CH_W:0]    diff;

    always_comb begin
        trial     = {rem_reg, quo_reg[DIV_N-1]};
        diff      = trial - {1'b0, dvs_reg};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (busy_reg) begin
            if (trial >= {1'b0, dvs_reg}) begin
                rem_next = diff[CH_W-1:0];
                quo_next = {quo_reg[DIV_N-2:0], 1'b1};
            end else begin
                rem_next = trial[CH_W-1:0];
                quo_next = {quo_reg[DIV_N-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= 5'(DIV_N);
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

### rtl/ghsp_dp.sv
// Datapath: configuration registers, delay line memory, row/column counters,
// ghost mix and darken arithmetic, output word register. Depends on ghsp_pkg, ghsp_div.
module ghsp_dp import ghsp_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [PIX_W-1:0]   s_pixel_in,
    input  logic               cfg_valid,
    input  logic [IDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]   cfg_data,
    input  cmd_t               cmd,
    output status_t            status,
    output logic [PIX_W-1:0]   m_pixel_out,
    output logic               m_last_of_run
);

    logic [1:0]        mode_reg;
    logic [DIM_W-1:0]  width_reg, height_reg;
    logic [ADDR_W-1:0] offset_reg;
    logic [CH_W-1:0]   divisor_reg, period_reg, darken_reg;

    logic [RECIP_W-1:0] recip_reg;
    logic [CH_W-1:0]    phase_reg;
    logic [COL_W-1:0]   col_reg;
    logic [COL_W-1:0]   row_reg;
    logic [ADDR_W-1:0]  fill_reg;

    logic [CNT_W-1:0]   nm_reg, nr_reg;
    logic               q_reg;
    logic [ADDR_W-1:0]  ptr_reg;
    logic [PIX_W-1:0]   pix_reg;
    logic               dark_reg;

    logic [PIX_W-1:0]   delay_mem [DEPTH];
    logic [PIX_W-1:0]   own_reg, src_reg;
    logic [PIX_W-1:0]   out_pix_reg;
    logic               out_last_reg;

    logic [DIM_W-1:0]   w_eff, h_eff;
    logic [CH_W-1:0]    div_eff, per_eff;
    logic               ghost;
    logic [CNT_W-1:0]   pend;
    logic               pend_over;
    logic [CNT_W-1:0]   n_ghost;
    logic [ADDR_W-1:0]  fill_after;
    logic               row_end;
    logic [CNT_W-1:0]   nm_plan, nr_plan;
    logic [DIM_W-1:0]   row_inc;
    logic [CH_W:0]      phase_inc;
    logic [CNT_W:0]     total;

    logic               div_done;
    logic [DIV_N-1:0]   div_quo;
    logic [CH_W-1:0]    div_rem;
    logic [DIV_N-1:0]   div_dividend;
    logic [CH_W-1:0]    div_divisor;

    function automatic logic [PIX_W-1:0] ghost_mix(
        input logic [PIX_W-1:0]   own,
        input logic [PIX_W-1:0]   src,
        input logic [RECIP_W-1:0] recip
    );
        logic [PIX_W-1:0]          res;
        logic [CH_W+RECIP_W-1:0]   prod;
        logic [CH_W+1:0]           sum;
        res = own;
        for (int k = 0; k < 3; k++) begin
            prod = src[k*CH_W +: CH_W] * recip;
            sum  = {2'b00, own[k*CH_W +: CH_W]} + {1'b0, prod[CH_W+RECIP_W-1:DIV_N]};
            res[k*CH_W +: CH_W] = (sum > {2'b00, CH_MAX}) ? CH_MAX : sum[CH_W-1:0];
        end
        return res;
    endfunction

    function automatic logic [PIX_W-1:0] darken(
        input logic [PIX_W-1:0] p,
        input logic [CH_W-1:0]  d
    );
        logic [PIX_W-1:0] res;
        res = p;
        for (int k = 0; k < 3; k++) begin
            res[k*CH_W +: CH_W] = (p[k*CH_W +: CH_W] >= d) ? p[k*CH_W +: CH_W] - d : '0;
        end
        return res;
    endfunction

    // effective register values
    always_comb begin
        if (width_reg == '0) w_eff = 11'd1;
        else if (width_reg > MAX_WIDTH) w_eff = MAX_WIDTH;
        else w_eff = width_reg;
        if (height_reg == '0) h_eff = 11'd1;
        else if (height_reg > MAX_WIDTH) h_eff = MAX_WIDTH;
        else h_eff = height_reg;
        div_eff = (divisor_reg == '0) ? 8'd1 : divisor_reg;
        per_eff = (period_reg == '0) ? 8'd1 : period_reg;
    end

    // plan the words of the item at the input
    always_comb begin
        ghost      = (mode_reg == MODE_GHOST) && ({5'b0, offset_reg} < w_eff);
        pend       = {1'b0, fill_reg} + 7'd1;
        pend_over  = pend > {1'b0, offset_reg};
        n_ghost    = pend_over ? pend - {1'b0, offset_reg} : '0;
        fill_after = pend_over ? offset_reg : pend[ADDR_W-1:0];
        row_end    = ({1'b0, col_reg} + 11'd1) >= w_eff;
        nm_plan    = ghost ? n_ghost : '0;
        if (ghost) nr_plan = row_end ? {1'b0, fill_after} : '0;
        else nr_plan = {1'b0, fill_reg};
        row_inc    = {1'b0, row_reg} + 11'd1;
        phase_inc  = {1'b0, phase_reg} + 9'd1;
        total      = {1'b0, nm_reg} + {1'b0, nr_reg} + {7'b0, q_reg};
    end

    assign div_dividend = cmd.div_sel_phase ? {6'b0, row_reg} : {DIV_N{1'b1}};
    assign div_divisor  = cmd.div_sel_phase ? per_eff : div_eff;

    ghsp_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= MODE_PASS;
            width_reg   <= 11'd640;
            height_reg  <= 11'd480;
            offset_reg  <= 6'd1;
            divisor_reg <= 8'd2;
            period_reg  <= 8'd2;
            darken_reg  <= 8'd32;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_MODE:    mode_reg    <= cfg_data[1:0];
                REG_WIDTH:   width_reg   <= cfg_data;
                REG_HEIGHT:  height_reg  <= cfg_data;
                REG_OFFSET:  offset_reg  <= cfg_data[ADDR_W-1:0];
                REG_DIVISOR: divisor_reg <= cfg_data[CH_W-1:0];
                REG_PERIOD:  period_reg  <= cfg_data[CH_W-1:0];
                REG_DARKEN:  darken_reg  <= cfg_data[CH_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            recip_reg <= RECIP_RESET;
            phase_reg <= '0;
            col_reg   <= '0;
            row_reg   <= '0;
            fill_reg  <= '0;
            nm_reg    <= '0;
            nr_reg    <= '0;
            q_reg     <= 1'b0;
            ptr_reg   <= '0;
        end else begin
            if (cmd.store_recip) begin
                recip_reg <= {1'b0, div_quo} + 17'd1;
            end
            if (cmd.store_phase) begin
                phase_reg <= div_rem;
            end
            if (cmd.item_take) begin
                nm_reg   <= nm_plan;
                nr_reg   <= nr_plan;
                q_reg    <= !ghost;
                ptr_reg  <= col_reg[ADDR_W-1:0] - fill_reg;
                fill_reg <= (ghost && !row_end) ? fill_after : '0;
                if (row_end) begin
                    col_reg <= '0;
                    if (row_inc >= h_eff) begin
                        row_reg   <= '0;
                        phase_reg <= '0;
                    end else begin
                        row_reg   <= row_inc[COL_W-1:0];
                        phase_reg <= (phase_inc >= {1'b0, per_eff}) ? '0 : phase_inc[CH_W-1:0];
                    end
                end else begin
                    col_reg <= col_reg + 10'd1;
                end
            end else if (cmd.advance) begin
                if (nm_reg != '0) begin
                    nm_reg  <= nm_reg - 7'd1;
                    ptr_reg <= ptr_reg + 6'd1;
                end else if (nr_reg != '0) begin
                    nr_reg  <= nr_reg - 7'd1;
                    ptr_reg <= ptr_reg + 6'd1;
                end else begin
                    q_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.item_take) begin
            pix_reg  <= s_pixel_in;
            dark_reg <= (mode_reg == MODE_SCAN) && (phase_reg == '0);
            if (ghost) begin
                delay_mem[col_reg[ADDR_W-1:0]] <= s_pixel_in;
            end
        end
        if (cmd.mem_rd) begin
            own_reg <= delay_mem[ptr_reg];
            src_reg <= delay_mem[ptr_reg + offset_reg];
        end
        if (cmd.out_load) begin
            if (nm_reg != '0) out_pix_reg <= ghost_mix(own_reg, src_reg, recip_reg);
            else if (nr_reg != '0) out_pix_reg <= own_reg;
            else if (dark_reg) out_pix_reg <= darken(pix_reg, darken_reg);
            else out_pix_reg <= pix_reg;
            out_last_reg <= (total == 8'd1);
        end
    end

    always_comb begin
        status.wr_divisor  = cfg_valid && (cfg_index == REG_DIVISOR);
        status.wr_period   = cfg_valid && (cfg_index == REG_PERIOD);
        status.div_done    = div_done;
        status.has_results = (nm_plan != '0) || (nr_plan != '0) || !ghost;
        status.more        = total > 8'd1;
    end

    assign m_pixel_out   = out_pix_reg;
    assign m_last_of_run = out_last_reg;

endmodule

### rtl/ghsp_ctrl.sv
// Controller: sequences item intake, per-word memory read / load / hand-off,
// and divider runs after divisor or period writes. Depends on ghsp_pkg.
module ghsp_ctrl import ghsp_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    output logic    m_valid,
    input  logic    m_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg, state_next;
    logic   pend_recip_reg, pend_recip_next;
    logic   pend_phase_reg, pend_phase_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            pend_recip_reg <= 1'b0;
            pend_phase_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            pend_recip_reg <= pend_recip_next;
            pend_phase_reg <= pend_phase_next;
        end
    end

    always_comb begin
        state_next      = state_reg;
        cmd             = '0;
        s_ready         = 1'b0;
        m_valid         = 1'b0;
        pend_recip_next = pend_recip_reg;
        pend_phase_next = pend_phase_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (pend_recip_reg) begin
                    cmd.div_start   = 1'b1;
                    pend_recip_next = 1'b0;
                    state_next      = ST_RECIP_WAIT;
                end else if (pend_phase_reg) begin
                    cmd.div_start     = 1'b1;
                    cmd.div_sel_phase = 1'b1;
                    pend_phase_next   = 1'b0;
                    state_next        = ST_PHASE_WAIT;
                end else begin
                    s_ready = 1'b1;
                    if (s_valid) begin
                        cmd.item_take = 1'b1;
                        state_next    = status.has_results ? ST_READ : ST_IDLE;
                    end
                end
            end
            ST_RECIP_WAIT: begin
                if (status.div_done) begin
                    cmd.store_recip = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            ST_PHASE_WAIT: begin
                if (status.div_done) begin
                    cmd.store_phase = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            ST_READ: begin
                cmd.mem_rd = 1'b1;
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                cmd.out_load = 1'b1;
                state_next   = ST_HOLD;
            end
            ST_HOLD: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    cmd.advance = 1'b1;
                    state_next  = status.more ? ST_READ : ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        if (status.wr_divisor) pend_recip_next = 1'b1;
        if (status.wr_period) pend_phase_next = 1'b1;
    end

endmodule

### rtl/ghost_scanline_pixel_effect_top.sv
// Each output word of an accepted pixel word passes a delay memory read (ST_READ) and an output
// register load (ST_LOAD) before it is valid; this repeats after each word is taken.
// No new input word is taken until every word produced for the last one has been handed off.
// A divisor or period write runs the 16-step shared divider; input waits until it is done.
// Reset (aresetn low, synchronous) restores register defaults and clears counters and control;
// the 64-word delay memory is not cleared.
module ghost_scanline_pixel_effect_top import ghsp_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [PIX_W-1:0]   s_pixel_in,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [PIX_W-1:0]   m_pixel_out,
    output logic               m_last_of_run,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [IDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]   cfg_data
);

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    ghsp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    ghsp_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_pixel_in    (s_pixel_in),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .cmd           (cmd),
        .status        (status),
        .m_pixel_out   (m_pixel_out),
        .m_last_of_run (m_last_of_run)
    );

endmodule

### rtl/ghsp_checker.sv
// Port-level checks for the ghost / scanline pixel effect top level.
// Depends on ghsp_pkg; bound to ghost_scanline_pixel_effect_top.
module ghsp_checker import ghsp_pkg::*; (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic [PIX_W-1:0]   m_pixel_out,
    input logic               m_last_of_run,
    input logic               cfg_valid,
    input logic               cfg_ready,
    input logic [IDX_W-1:0]   cfg_index
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_pixel_out) && $stable(m_last_of_run))
        else $error("output word changed while stalled");

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input taken while output word pending");

    a_run_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last_of_run |=> !s_ready)
        else $error("input taken before run finished");

    a_recalc: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid && cfg_ready && (cfg_index == REG_DIVISOR || cfg_index == REG_PERIOD)
        |=> !s_ready)
        else $error("input taken before divider recompute");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

endmodule

bind ghost_scanline_pixel_effect_top ghsp_checker u_ghsp_checker (.*);

### tb/tb_ghost_scanline_pixel_effect_top.sv
`timescale 1ns / 1ps
// Self-checking bench for ghost_scanline_pixel_effect_top: a scoreboard class predicts every
// output word from the accepted pixels and register writes. Depends on ghsp_pkg and the RTL.
module tb_ghost_scanline_pixel_effect_top;
    import ghsp_pkg::*;

    localparam logic [1:0]  MODE_UNUSED    = 2'd3;
    localparam int unsigned PIXEL_TARGET   = 350;
    localparam int unsigned TAIL_CYCLES    = 10;
    localparam int unsigned WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             last;
    } out_word_t;

    class pixel_effect_scoreboard;
        logic [1:0]        mode;
        logic [DIM_W-1:0]  width;
        logic [DIM_W-1:0]  height;
        logic [ADDR_W-1:0] offset;
        logic [CH_W-1:0]   divisor;
        logic [CH_W-1:0]   period;
        logic [CH_W-1:0]   darken;
        logic [PIX_W-1:0]  line_buf [DEPTH];
        int unsigned       col, row, held;
        out_word_t         due_words [$];
        int unsigned       errors, pixels_in, words_out, rows_done;

        function new();
            mode = MODE_PASS;
            width = 640;
            height = 480;
            offset = 1;
            divisor = 2;
            period = 2;
            darken = 32;
            foreach (line_buf[i]) line_buf[i] = '0;
            col = 0;
            row = 0;
            held = 0;
            errors = 0;
            pixels_in = 0;
            words_out = 0;
            rows_done = 0;
        endfunction

        function void load_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (cfg_reg_t'(idx))
                REG_MODE:    mode = data[1:0];
                REG_WIDTH:   width = data;
                REG_HEIGHT:  height = data;
                REG_OFFSET:  offset = data[ADDR_W-1:0];
                REG_DIVISOR: divisor = data[CH_W-1:0];
                REG_PERIOD:  period = data[CH_W-1:0];
                REG_DARKEN:  darken = data[CH_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [PIX_W-1:0] ghost_blend(logic [PIX_W-1:0] own, logic [PIX_W-1:0] src,
                                               int unsigned dv);
            logic [PIX_W-1:0] res;
            int unsigned      sum;
            res = own;
            for (int c = 0; c < 3; c++) begin
                sum = int'(own[8*c +: 8]) + int'(src[8*c +: 8]) / dv;
                res[8*c +: 8] = (sum > CH_MAX) ? CH_MAX : sum[CH_W-1:0];
            end
            return res;
        endfunction

        function logic [PIX_W-1:0] scan_dim(logic [PIX_W-1:0] pix);
            logic [PIX_W-1:0] res;
            res = pix;
            for (int c = 0; c < 3; c++)
                res[8*c +: 8] = (pix[8*c +: 8] >= darken) ? pix[8*c +: 8] - darken : 8'd0;
            return res;
        endfunction

        function void queue_word(logic [PIX_W-1:0] pix);
            out_word_t word;
            word.pixel = pix;
            word.last = 1'b0;
            due_words.push_back(word);
        endfunction

        function void take_pixel(logic [PIX_W-1:0] pix);
            int unsigned      w, h, off, dv, per, pend, o, first;
            logic [PIX_W-1:0] q;
            w = (width == 0) ? 1 : (width > MAX_WIDTH) ? MAX_WIDTH : width;
            h = (height == 0) ? 1 : (height > MAX_WIDTH) ? MAX_WIDTH : height;
            off = offset;
            dv = (divisor == 0) ? 1 : divisor;
            per = (period == 0) ? 1 : period;
            first = due_words.size();
            pixels_in++;
            if (mode == MODE_GHOST && off < w) begin
                pend = held + 1;
                line_buf[col % DEPTH] = pix;
                while (pend > off) begin
                    o = col - (pend - 1);
                    queue_word(ghost_blend(line_buf[o % DEPTH], line_buf[(o + off) % DEPTH], dv));
                    pend--;
                end
                held = pend;
            end else begin
                for (int unsigned k = held; k >= 1; k--)
                    queue_word(line_buf[(col - k) % DEPTH]);
                held = 0;
                q = pix;
                if (mode == MODE_SCAN && (row % per) == 0)
                    q = scan_dim(q);
                queue_word(q);
            end
            if (col + 1 >= w) begin
                for (int unsigned k = held; k >= 1; k--)
                    queue_word(line_buf[(col - (k - 1)) % DEPTH]);
                held = 0;
                col = 0;
                row++;
                rows_done++;
                if (row >= h)
                    row = 0;
            end else begin
                col++;
            end
            if (due_words.size() > first)
                due_words[due_words.size() - 1].last = 1'b1;
        endfunction

        task flag_mismatch(string what);
            errors++;
            $display("mismatch @%0t: %s", $time, what);
        endtask

        task check_word(logic [PIX_W-1:0] pix, logic last);
            out_word_t want;
            words_out++;
            if (due_words.size() == 0) begin
                flag_mismatch($sformatf("word %h arrived with nothing due", pix));
                return;
            end
            want = due_words.pop_front();
            if (pix !== want.pixel)
                flag_mismatch($sformatf("pixel_out %h, want %h", pix, want.pixel));
            if (last !== want.last)
                flag_mismatch($sformatf("last_of_run %b, want %b (pixel %h)",
                                        last, want.last, want.pixel));
        endtask

        task check_drained();
            if (due_words.size() != 0)
                flag_mismatch($sformatf("%0d words never arrived", due_words.size()));
        endtask
    endclass

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    logic [PIX_W-1:0]  s_pixel_in;
    logic              m_valid;
    logic              m_ready;
    logic [PIX_W-1:0]  m_pixel_out;
    logic              m_last_of_run;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [IDX_W-1:0]  cfg_index;
    logic [CFG_W-1:0]  cfg_data;

    pixel_effect_scoreboard sb;
    bit                     steady;
    int unsigned            sent;
    int unsigned            cfg_writes;
    int unsigned            quiet_cycles;

    ghost_scanline_pixel_effect_top uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_pixel_in    (s_pixel_in),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pixel_out   (m_pixel_out),
        .m_last_of_run (m_last_of_run),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    always @(negedge aclk) begin
        m_ready <= steady || ($urandom_range(99) >= 13);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            quiet_cycles++;
            if (cfg_valid && cfg_ready) begin
                sb.load_reg(cfg_index, cfg_data);
                quiet_cycles = 0;
            end
            if (s_valid && s_ready) begin
                sb.take_pixel(s_pixel_in);
                quiet_cycles = 0;
            end
            if (m_valid && m_ready) begin
                sb.check_word(m_pixel_out, m_last_of_run);
                quiet_cycles = 0;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: %0d cycles without a handshake", quiet_cycles);
                $display("tb_ghost_scanline_pixel_effect_top: errors");
                $finish;
            end
        end
    end

    task automatic write_reg(cfg_reg_t idx, int unsigned val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_W'(val);
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        cfg_writes++;
    endtask

    // hold input until every due word is out, then let the pipe go quiet
    task automatic settle();
        s_valid <= 1'b0;
        while (sb.due_words.size() != 0)
            @(negedge aclk);
        repeat (TAIL_CYCLES) @(negedge aclk);
    endtask

    task automatic send_pixel(logic [PIX_W-1:0] pix);
        while (!steady && $urandom_range(99) < 13) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_pixel_in <= pix;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        sent++;
        if (!steady && $urandom_range(49) == 0)
            settle();
    endtask

    task automatic random_phase();
        int unsigned      pick, w, off, n;
        logic [1:0]       md;
        logic [PIX_W-1:0] pix;
        settle();
        pick = $urandom_range(99);
        if (pick < 50) md = MODE_GHOST;
        else if (pick < 75) md = MODE_SCAN;
        else if (pick < 88) md = MODE_PASS;
        else md = MODE_UNUSED;
        pick = $urandom_range(99);
        if (pick < 35) off = $urandom_range(3, 0);
        else if (pick < 70) off = $urandom_range(15, 4);
        else if (pick < 85) off = 63;
        else off = $urandom_range(62, 16);
        pick = $urandom_range(99);
        if (pick < 60) w = $urandom_range(16, 1);
        else if (pick < 85) w = $urandom_range(130, 17);
        else if (pick < 92) w = $urandom_range(700, 131);
        else begin
            case ($urandom_range(2))
                0: w = 0;
                1: w = 1024;
                default: w = 2047;
            endcase
        end
        if (off >= 16 && $urandom_range(1) == 1)
            w = off + $urandom_range(40, 1);
        write_reg(REG_MODE, md);
        write_reg(REG_WIDTH, w);
        pick = $urandom_range(99);
        if (pick < 70) write_reg(REG_HEIGHT, $urandom_range(6, 0));
        else if (pick < 85) write_reg(REG_HEIGHT, $urandom_range(40, 7));
        else if (pick < 93) write_reg(REG_HEIGHT, 1024);
        else write_reg(REG_HEIGHT, 2047);
        write_reg(REG_OFFSET, off);
        case ($urandom_range(5))
            0: write_reg(REG_DIVISOR, 0);
            1: write_reg(REG_DIVISOR, 1);
            2: write_reg(REG_DIVISOR, 255);
            3: write_reg(REG_DIVISOR, $urandom_range(8, 2));
            default: write_reg(REG_DIVISOR, $urandom_range(254, 2));
        endcase
        case ($urandom_range(5))
            0: write_reg(REG_PERIOD, 0);
            1: write_reg(REG_PERIOD, 1);
            2: write_reg(REG_PERIOD, 255);
            default: write_reg(REG_PERIOD, $urandom_range(4, 2));
        endcase
        case ($urandom_range(3))
            0: write_reg(REG_DARKEN, 0);
            1: write_reg(REG_DARKEN, 255);
            default: write_reg(REG_DARKEN, $urandom_range(254, 1));
        endcase
        n = $urandom_range(40, 8);
        for (int i = 0; i < n && sent < PIXEL_TARGET; i++) begin
            steady = (sent >= 150 && sent < 230);
            pick = $urandom_range(99);
            pix = $urandom;
            if (pick < 8) pix = '0;
            else if (pick < 16) pix = '1;
            else if (pick < 30) begin
                for (int b = 0; b < 4; b++)
                    if ($urandom_range(1) == 1)
                        pix[8*b +: 8] = ($urandom_range(1) == 1) ? 8'hFF : 8'h00;
            end
            send_pixel(pix);
        end
        steady = 1'b0;
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_pixel_in = '0;
        m_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_MODE;
        cfg_data = '0;
        steady = 1'b0;
        sent = 0;
        cfg_writes = 0;
        quiet_cycles = 0;
        sb = new();
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // narrow rows, height zero, divisor zero, period zero, full darken
        write_reg(REG_MODE, MODE_GHOST);
        write_reg(REG_WIDTH, 4);
        write_reg(REG_HEIGHT, 0);
        write_reg(REG_OFFSET, 2);
        write_reg(REG_DIVISOR, 0);
        write_reg(REG_PERIOD, 0);
        write_reg(REG_DARKEN, 255);
        send_pixel(32'hFFFF_FFFF);
        send_pixel(32'h7F7F_7F7F);
        send_pixel(32'h00FF_0001);
        send_pixel(32'h1234_5678);
        settle();
        write_reg(REG_MODE, MODE_SCAN);
        send_pixel(32'hFFFF_FFFF);
        send_pixel(32'h0000_0000);
        settle();
        write_reg(REG_MODE, MODE_UNUSED);
        send_pixel(32'hA5A5_A5A5);
        send_pixel(32'h5A5A_5A5A);
        settle();
        // offset not below width
        write_reg(REG_MODE, MODE_GHOST);
        write_reg(REG_OFFSET, 5);
        send_pixel(32'h8080_8080);
        send_pixel(32'h0102_0304);
        settle();
        // shrink width under the current column
        write_reg(REG_WIDTH, 2);
        send_pixel(32'hFEDC_BA98);
        settle();
        // leave ghosting with words held
        write_reg(REG_WIDTH, 8);
        write_reg(REG_OFFSET, 3);
        write_reg(REG_DIVISOR, 1);
        send_pixel(32'h1111_1111);
        send_pixel(32'h2222_2222);
        send_pixel(32'h3333_3333);
        settle();
        write_reg(REG_MODE, MODE_PASS);
        send_pixel(32'h4444_4444);
        settle();
        // lower the offset mid-row
        write_reg(REG_MODE, MODE_GHOST);
        write_reg(REG_OFFSET, 4);
        send_pixel(32'hC0C0_C0C0);
        send_pixel(32'h6060_6060);
        settle();
        write_reg(REG_OFFSET, 1);
        send_pixel(32'hF0F0_F0F0);
        send_pixel(32'h0F0F_0F0F);
        settle();
        // width zero, then width and height above the maximum
        write_reg(REG_WIDTH, 0);
        write_reg(REG_MODE, MODE_SCAN);
        write_reg(REG_PERIOD, 1);
        write_reg(REG_DARKEN, 16);
        send_pixel(32'h0810_20FF);
        settle();
        write_reg(REG_WIDTH, 2047);
        write_reg(REG_HEIGHT, 2047);
        send_pixel(32'hFFFF_FFFF);
        send_pixel(32'h0000_0000);

        while (sent < PIXEL_TARGET)
            random_phase();
        settle();
        sb.check_drained();

        $display("%0d pixel words in, %0d words out checked, %0d rows closed",
                 sb.pixels_in, sb.words_out, sb.rows_done);
        $display("%0d register writes across all four modes; %0d mismatches",
                 cfg_writes, sb.errors);
        if (sb.errors == 0)
            $display("tb_ghost_scanline_pixel_effect_top: clean");
        else
            $display("tb_ghost_scanline_pixel_effect_top: errors");
        $finish;
    end

endmodule
